/* rtl/core/mel_pkg.sv */
// Package for the expression lexer: types, codes, constants and character helpers.
package mel_pkg;

    // Longest token text is TOKEN_CAP - 1 bytes.
    localparam int TOKEN_CAP = 64;
    localparam int TLEN_W    = $clog2(TOKEN_CAP);
    localparam int CAP_W     = TLEN_W + 1;

    // Result queue depth; two slots must be free before a character is processed.
    localparam int Q_DEPTH = 4;
    localparam int QA_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] SAT16 = 16'hFFFF;

    // Characters with a special meaning.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_US    = 8'h5F;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_PT    = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_CARET = 8'h5E;

    // Event codes of a result beat.
    typedef enum logic [1:0] {
        EV_TEXT = 2'd0,
        EV_DONE = 2'd1,
        EV_ERR  = 2'd2
    } t_event;

    // Token kinds.
    typedef enum logic [3:0] {
        K_END    = 4'd0,
        K_NUM    = 4'd1,
        K_ID     = 4'd2,
        K_PIPE   = 4'd3,
        K_LPAR   = 4'd4,
        K_RPAR   = 4'd5,
        K_LBRK   = 4'd6,
        K_RBRK   = 4'd7,
        K_COMMA  = 4'd8,
        K_PLUS   = 4'd9,
        K_MINUS  = 4'd10,
        K_STAR   = 4'd11,
        K_SLASH  = 4'd12,
        K_PCT    = 4'd13,
        K_CARET  = 4'd14
    } t_kind;

    // Error codes.
    typedef enum logic [2:0] {
        E_UNEXP    = 3'd0,
        E_EXP_TWICE = 3'd1,
        E_PT_IN_EXP = 3'd2,
        E_PT_TWICE  = 3'd3,
        E_NO_DIGIT  = 3'd4,
        E_TOO_LONG  = 3'd5
    } t_err;

    // One result beat.
    typedef struct packed {
        logic [1:0]  event_res;
        logic [3:0]  token_kind;
        logic [7:0]  text_byte;
        logic [15:0] line;
        logic [15:0] column;
        logic [5:0]  token_length;
        logic        space_before;
        logic [2:0]  error_code;
        logic        last;
    } t_res;

    // Results produced by one character, from the lexer to the queue.
    typedef struct packed {
        logic [1:0]       cnt;
        t_res [1:0]       res;
    } t_step;

    // Queue status seen by the input stage.
    typedef struct packed {
        logic room2;
    } t_qstat;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    // Kind of a one-character token, K_END when the character is none.
    function automatic logic [3:0] single_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            CH_PIPE:  k = K_PIPE;
            8'h28:    k = K_LPAR;
            8'h29:    k = K_RPAR;
            8'h5B:    k = K_LBRK;
            8'h5D:    k = K_RBRK;
            8'h2C:    k = K_COMMA;
            CH_PLUS:  k = K_PLUS;
            CH_MINUS: k = K_MINUS;
            8'h2A:    k = K_STAR;
            8'h2F:    k = K_SLASH;
            8'h25:    k = K_PCT;
            CH_CARET: k = K_CARET;
            default:  k = K_END;
        endcase
        return k;
    endfunction

    // Builds a result beat; the last flag is set later.
    function automatic t_res mk_res(
        input logic [1:0]        ev,
        input logic [3:0]        kind,
        input logic [7:0]        byte_v,
        input logic [15:0]       ln,
        input logic [15:0]       col,
        input logic [TLEN_W-1:0] len,
        input logic              sp,
        input logic [2:0]        err
    );
        t_res r;
        r.event_res    = ev;
        r.token_kind   = kind;
        r.text_byte    = byte_v;
        r.line         = ln;
        r.column       = col;
        r.token_length = 6'(len);
        r.space_before = sp;
        r.error_code   = err;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

/* rtl/core/mel_if.sv */
// Stream interfaces for the lexer: character input and result output.
interface mel_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink (input valid, input in_char, output ready);
endinterface

interface mel_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [3:0]  token_kind;
    logic [7:0]  text_byte;
    logic [15:0] line;
    logic [15:0] column;
    logic [5:0]  token_length;
    logic        space_before;
    logic [2:0]  error_code;
    logic        last;

    modport source (
        output valid, output event_res, output token_kind, output text_byte,
        output line, output column, output token_length, output space_before,
        output error_code, output last, input ready
    );
    modport sink (
        input valid, input event_res, input token_kind, input text_byte,
        input line, input column, input token_length, input space_before,
        input error_code, input last, output ready
    );
endinterface

/* rtl/core/mel_core.sv */
// Lexer state and the single-pass step that turns one character into up to two results.
module mel_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step_en,
    input  logic [7:0]          i_char,
    output mel_pkg::t_step      o_step
);

    typedef enum logic [6:0] {
        M_IDLE  = 7'b0000001,
        M_NUM   = 7'b0000010,
        M_EXP   = 7'b0000100,
        M_SIGN  = 7'b0001000,
        M_POINT = 7'b0010000,
        M_ID    = 7'b0100000,
        M_ERR   = 7'b1000000
    } t_mode;

    t_mode                       r_mode, n_mode;
    logic                        r_exp, n_exp;
    logic                        r_pt, n_pt;
    logic [15:0]                 r_line, n_line;
    logic [15:0]                 r_col, n_col;
    logic [15:0]                 r_sline, n_sline;
    logic [15:0]                 r_scol, n_scol;
    logic [mel_pkg::TLEN_W-1:0]  r_tlen, n_tlen;
    logic                        r_sp, n_sp;

    // Step: token continuation, token end, between-token handling, text byte, error beat, then position update.
    always_comb begin
        logic       do_fin;
        logic [3:0] fin_kind;
        logic       do_btw;
        logic       do_add;
        logic [3:0] add_kind;
        logic       do_fail;
        logic [2:0] fail_code;
        logic [3:0] sk;
        logic [1:0] k;
        mel_pkg::t_res [1:0] res;

        do_fin    = 1'b0;
        fin_kind  = mel_pkg::K_END;
        do_btw    = 1'b0;
        do_add    = 1'b0;
        add_kind  = mel_pkg::K_END;
        do_fail   = 1'b0;
        fail_code = mel_pkg::E_UNEXP;
        sk        = mel_pkg::single_kind(i_char);
        k         = 2'd0;
        res       = '0;

        n_mode  = r_mode;
        n_exp   = r_exp;
        n_pt    = r_pt;
        n_line  = r_line;
        n_col   = r_col;
        n_sline = r_sline;
        n_scol  = r_scol;
        n_tlen  = r_tlen;
        n_sp    = r_sp;

        // Continue or end the token under construction.
        case (r_mode)
            M_ERR: begin
            end
            M_ID: begin
                if (mel_pkg::is_alpha(i_char) || mel_pkg::is_digit(i_char)) begin
                    do_add   = 1'b1;
                    add_kind = mel_pkg::K_ID;
                end else begin
                    do_fin   = 1'b1;
                    fin_kind = mel_pkg::K_ID;
                    do_btw   = 1'b1;
                end
            end
            M_NUM: begin
                if (i_char == mel_pkg::CH_US) begin
                    // Underscores are skipped.
                end else if (i_char == mel_pkg::CH_E) begin
                    if (r_exp) begin
                        do_fail   = 1'b1;
                        fail_code = mel_pkg::E_EXP_TWICE;
                    end else begin
                        n_exp    = 1'b1;
                        n_mode   = M_EXP;
                        do_add   = 1'b1;
                        add_kind = mel_pkg::K_NUM;
                    end
                end else if (i_char == mel_pkg::CH_PT) begin
                    if (r_exp) begin
                        do_fail   = 1'b1;
                        fail_code = mel_pkg::E_PT_IN_EXP;
                    end else if (r_pt) begin
                        do_fail   = 1'b1;
                        fail_code = mel_pkg::E_PT_TWICE;
                    end else begin
                        n_pt     = 1'b1;
                        n_mode   = M_POINT;
                        do_add   = 1'b1;
                        add_kind = mel_pkg::K_NUM;
                    end
                end else if (mel_pkg::is_digit(i_char)) begin
                    do_add   = 1'b1;
                    add_kind = mel_pkg::K_NUM;
                end else begin
                    do_fin   = 1'b1;
                    fin_kind = mel_pkg::K_NUM;
                    do_btw   = 1'b1;
                end
            end
            M_EXP: begin
                if (i_char == mel_pkg::CH_PLUS || i_char == mel_pkg::CH_MINUS) begin
                    n_mode   = M_SIGN;
                    do_add   = 1'b1;
                    add_kind = mel_pkg::K_NUM;
                end else if (mel_pkg::is_digit(i_char)) begin
                    n_mode   = M_NUM;
                    do_add   = 1'b1;
                    add_kind = mel_pkg::K_NUM;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = mel_pkg::E_NO_DIGIT;
                end
            end
            M_SIGN, M_POINT: begin
                if (mel_pkg::is_digit(i_char)) begin
                    n_mode   = M_NUM;
                    do_add   = 1'b1;
                    add_kind = mel_pkg::K_NUM;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = mel_pkg::E_NO_DIGIT;
                end
            end
            default: begin
                do_btw = 1'b1;
            end
        endcase

        // Record for a number or identifier that this character ends.
        if (do_fin) begin
            res[k[0]] = mel_pkg::mk_res(mel_pkg::EV_DONE, fin_kind, 8'h00, n_sline, n_scol,
                                        n_tlen, n_sp, mel_pkg::E_UNEXP);
            k      = k + 2'd1;
            n_sp   = 1'b0;
            n_mode = M_IDLE;
        end

        // Character seen between tokens.
        if (do_btw) begin
            n_mode = M_IDLE;
            if (i_char == mel_pkg::CH_NUL) begin
                res[k[0]] = mel_pkg::mk_res(mel_pkg::EV_DONE, mel_pkg::K_END, 8'h00, n_line,
                                            n_col, '0, n_sp, mel_pkg::E_UNEXP);
                k = k + 2'd1;
            end else if (mel_pkg::is_space(i_char)) begin
                n_sp = 1'b1;
            end else if (sk != mel_pkg::K_END) begin
                n_sline = n_line;
                n_scol  = n_col;
                n_tlen  = '0;
                n_exp   = 1'b0;
                n_pt    = 1'b0;
                res[k[0]] = mel_pkg::mk_res(mel_pkg::EV_DONE, sk, 8'h00, n_sline, n_scol,
                                            n_tlen, n_sp, mel_pkg::E_UNEXP);
                k    = k + 2'd1;
                n_sp = 1'b0;
            end else if (mel_pkg::is_digit(i_char) || mel_pkg::is_alpha(i_char)) begin
                n_sline  = n_line;
                n_scol   = n_col;
                n_tlen   = '0;
                n_exp    = 1'b0;
                n_pt     = 1'b0;
                n_mode   = mel_pkg::is_digit(i_char) ? M_NUM : M_ID;
                do_add   = 1'b1;
                add_kind = mel_pkg::is_digit(i_char) ? mel_pkg::K_NUM : mel_pkg::K_ID;
            end else begin
                do_fail   = 1'b1;
                fail_code = mel_pkg::E_UNEXP;
            end
        end

        // Keep a text byte unless the token would reach its capacity.
        if (do_add) begin
            if (mel_pkg::CAP_W'(n_tlen) + mel_pkg::CAP_W'(1) >=
                mel_pkg::CAP_W'(mel_pkg::TOKEN_CAP)) begin
                do_fail   = 1'b1;
                fail_code = mel_pkg::E_TOO_LONG;
            end else begin
                n_tlen = n_tlen + mel_pkg::TLEN_W'(1);
                res[k[0]] = mel_pkg::mk_res(mel_pkg::EV_TEXT, add_kind, i_char, n_sline,
                                            n_scol, n_tlen, n_sp, mel_pkg::E_UNEXP);
                k = k + 2'd1;
            end
        end

        // Error beat at the current position.
        if (do_fail) begin
            n_mode = M_ERR;
            res[k[0]] = mel_pkg::mk_res(mel_pkg::EV_ERR, mel_pkg::K_END, i_char, n_line,
                                        n_col, '0, 1'b0, fail_code);
            k = k + 2'd1;
        end

        // Position tracking; end of input restarts the lexer.
        if (i_char == mel_pkg::CH_NUL) begin
            n_mode = M_IDLE;
            n_exp  = 1'b0;
            n_pt   = 1'b0;
            n_line = 16'd1;
            n_col  = 16'd1;
            n_tlen = '0;
            n_sp   = 1'b0;
        end else if (i_char == mel_pkg::CH_NL) begin
            if (n_line != mel_pkg::SAT16) begin
                n_line = n_line + 16'd1;
            end
            n_col = 16'd1;
        end else if (n_col != mel_pkg::SAT16) begin
            n_col = n_col + 16'd1;
        end

        if (k == 2'd1) begin
            res[0].last = 1'b1;
        end else if (k == 2'd2) begin
            res[1].last = 1'b1;
        end

        o_step.cnt = i_step_en ? k : 2'd0;
        o_step.res = res;
    end

    // State registers advance once per processed character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_exp   <= 1'b0;
            r_pt    <= 1'b0;
            r_line  <= 16'd1;
            r_col   <= 16'd1;
            r_sline <= 16'd1;
            r_scol  <= 16'd1;
            r_tlen  <= '0;
            r_sp    <= 1'b0;
        end else if (i_step_en) begin
            r_mode  <= n_mode;
            r_exp   <= n_exp;
            r_pt    <= n_pt;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_tlen  <= n_tlen;
            r_sp    <= n_sp;
        end
    end

`ifndef SYNTHESIS
    // End of input always restarts position and mode.
    a_nul_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step_en && i_char == mel_pkg::CH_NUL |=>
        r_line == 16'd1 && r_col == 16'd1 && r_mode == M_IDLE)
        else $error("lexer did not restart after end of input");

    // Two results only when a token ends, and only the second is marked last.
    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step.cnt == 2'd2 |->
        o_step.res[0].event_res == mel_pkg::EV_DONE && o_step.res[1].last &&
        !o_step.res[0].last)
        else $error("bad pair of results");

    // Error mode stays silent until end of input.
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step_en && r_mode == M_ERR && i_char != mel_pkg::CH_NUL |->
        o_step.cnt == 2'd0 ##1 r_mode == M_ERR)
        else $error("lexer left error mode early");
`endif

endmodule

/* rtl/core/mel_queue.sv */
// Result queue: takes up to two beats per cycle and hands out one.
module mel_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mel_pkg::t_step     i_step,
    input  logic               i_pop,
    output logic               o_valid,
    output mel_pkg::t_res      o_head,
    output mel_pkg::t_qstat    o_stat
);

    mel_pkg::t_res               r_mem [mel_pkg::Q_DEPTH];
    logic [mel_pkg::QA_W-1:0]    r_head, r_tail;
    logic [mel_pkg::QC_W-1:0]    r_count;
    logic [mel_pkg::QC_W-1:0]    n_count;
    logic                        pop;

    assign pop          = i_pop && (r_count != '0);
    assign o_valid      = (r_count != '0);
    assign o_head       = r_mem[r_head];
    assign o_stat.room2 = (r_count <= mel_pkg::QC_W'(mel_pkg::Q_DEPTH - 2));
    assign n_count      = r_count + mel_pkg::QC_W'(i_step.cnt) - mel_pkg::QC_W'(pop);

    // Payload storage.
    always_ff @(posedge i_clk) begin
        if (i_step.cnt != 2'd0) begin
            r_mem[r_tail] <= i_step.res[0];
        end
        if (i_step.cnt == 2'd2) begin
            r_mem[r_tail + mel_pkg::QA_W'(1)] <= i_step.res[1];
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + mel_pkg::QA_W'(i_step.cnt);
            r_head  <= r_head + mel_pkg::QA_W'(pop);
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    // Fill count never passes the depth.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mel_pkg::QC_W'(mel_pkg::Q_DEPTH))
        else $error("result queue overflow");

    // A push is only offered when there is room for it.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.cnt != 2'd0 |-> o_stat.room2)
        else $error("push into full result queue");

    // A lone pop drops the count by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_step.cnt == 2'd0 |=> r_count == $past(r_count) - mel_pkg::QC_W'(1))
        else $error("queue count wrong after pop");
`endif

endmodule

/* rtl/core/math_expression_lexer.sv */
// A character accepted into the input register is processed once the queue has room for two
// beats, and its results are registered in the queue. Throughput: one character per cycle
// while each causes at most one result and the queue has room for two beats; a character
// that ends a token and starts or errors another gives two beats through one output port.
// The lexer step is one combinational pass between the input register and a 4-beat queue.
// Reset (i_rst_n low, synchronous) empties the queue and returns to line 1, column 1.
module math_expression_lexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mel_in_if.sink      i_in,
    mel_out_if.source   o_out
);

    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_in_char;
    logic             in_fire;
    logic             step_go;
    mel_pkg::t_step   step;
    mel_pkg::t_res    head;
    mel_pkg::t_qstat  qstat;

    // Input stage advances when the queue can take two beats.
    assign step_go    = r_in_valid && qstat.room2;
    assign i_in.ready = !r_in_valid || step_go;
    assign in_fire    = i_in.valid && i_in.ready;
    assign n_in_valid = in_fire ? 1'b1 : (step_go ? 1'b0 : r_in_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_char <= i_in.in_char;
        end
    end

    mel_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step_en (step_go),
        .i_char    (r_in_char),
        .o_step    (step)
    );

    mel_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // Output beat fields.
    assign o_out.event_res    = head.event_res;
    assign o_out.token_kind   = head.token_kind;
    assign o_out.text_byte    = head.text_byte;
    assign o_out.line         = head.line;
    assign o_out.column       = head.column;
    assign o_out.token_length = head.token_length;
    assign o_out.space_before = head.space_before;
    assign o_out.error_code   = head.error_code;
    assign o_out.last         = head.last;

`ifndef SYNTHESIS
    // A held character is not replaced before it is processed.
    a_hold_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step_go |=> r_in_valid && $stable(r_in_char))
        else $error("input character lost");

    // The input stage takes no beat while a stalled character waits.
    a_no_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !qstat.room2 |-> !i_in.ready)
        else $error("input accepted while stalled");

    // Results only come from processed characters.
    a_step_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.cnt != 2'd0 |-> step_go)
        else $error("result without a character");
`endif

endmodule

/* dv/tb_math_expression_lexer.sv */
// Self-checking testbench for the expression lexer: directed table and random expressions.
`timescale 1ns / 100ps

module tb_math_expression_lexer;

    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS       = 1800;

    // Lexer modes of the predictor.
    typedef enum logic [2:0] {
        LX_IDLE, LX_NUM, LX_EXP, LX_SIGN, LX_POINT, LX_ID, LX_ERR
    } t_lex;

    // One row of the directed table; typed rows carry the last beat's codes.
    typedef struct {
        logic [7:0]      ch;
        bit              typed;
        mel_pkg::t_event ev;
        mel_pkg::t_kind  kind;
        mel_pkg::t_err   err;
    } t_row;

    localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
    localparam string      OPS        = "|()[],+-*/%^";

    logic i_clk;
    logic i_rst_n;

    mel_in_if  in_if ();
    mel_out_if out_if ();

    math_expression_lexer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predictor state.
    t_lex          lx_mode;
    bit            exp_seen;
    bit            pt_seen;
    bit            sp_seen;
    logic [15:0]   cur_line;
    logic [15:0]   cur_col;
    logic [15:0]   tok_line;
    logic [15:0]   tok_col;
    int unsigned   tok_len;
    mel_pkg::t_res step_buf [2];
    int            step_n;

    // Beats still owed by the lexer, oldest first.
    mel_pkg::t_res want_q [$];
    logic [7:0]    stim_q [$];

    bit calm = 1'b0;
    int stall_cycles = 0;
    int bad_count = 0;
    int sent_items = 0;
    int live_items = 0;
    int beats_seen = 0;
    int tokens_seen = 0;
    int errors_seen = 0;

    // Directed text: "\0 1_.5e-7." "\0" "2.3." "\0" "9e1e" "\0" "x+" 0xFF "\0" "1e\0".
    t_row dir_rows [0:27] = '{
        '{8'h00, 1'b1, mel_pkg::EV_DONE, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{" ",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"1",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"_",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{".",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"5",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"e",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"-",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"7",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{".",   1'b1, mel_pkg::EV_ERR,  mel_pkg::K_END,  mel_pkg::E_PT_IN_EXP},
        '{8'h00, 1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"2",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{".",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"3",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{".",   1'b1, mel_pkg::EV_ERR,  mel_pkg::K_END,  mel_pkg::E_PT_TWICE},
        '{8'h00, 1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"9",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"e",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"1",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"e",   1'b1, mel_pkg::EV_ERR,  mel_pkg::K_END,  mel_pkg::E_EXP_TWICE},
        '{8'h00, 1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"x",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"+",   1'b1, mel_pkg::EV_DONE, mel_pkg::K_PLUS, mel_pkg::E_UNEXP},
        '{8'hFF, 1'b1, mel_pkg::EV_ERR,  mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{8'h00, 1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"1",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{"e",   1'b0, mel_pkg::EV_TEXT, mel_pkg::K_END,  mel_pkg::E_UNEXP},
        '{8'h00, 1'b1, mel_pkg::EV_ERR,  mel_pkg::K_END,  mel_pkg::E_NO_DIGIT}
    };

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Character classes.
    function automatic bit digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter_ch(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit blank_ch(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic mel_pkg::t_kind op_kind(input logic [7:0] c);
        case (c)
            "|":     return mel_pkg::K_PIPE;
            "(":     return mel_pkg::K_LPAR;
            ")":     return mel_pkg::K_RPAR;
            "[":     return mel_pkg::K_LBRK;
            "]":     return mel_pkg::K_RBRK;
            ",":     return mel_pkg::K_COMMA;
            "+":     return mel_pkg::K_PLUS;
            "-":     return mel_pkg::K_MINUS;
            "*":     return mel_pkg::K_STAR;
            "/":     return mel_pkg::K_SLASH;
            "%":     return mel_pkg::K_PCT;
            "^":     return mel_pkg::K_CARET;
            default: return mel_pkg::K_END;
        endcase
    endfunction

    function automatic string show(input mel_pkg::t_res r);
        return {$sformatf("ev=%0d kind=%0d byte=%02h ln=%0d col=%0d", r.event_res,
                          r.token_kind, r.text_byte, r.line, r.column),
                $sformatf(" len=%0d sp=%0d err=%0d last=%0d", r.token_length,
                          r.space_before, r.error_code, r.last)};
    endfunction

    function automatic void flag_bad(input string msg);
        bad_count++;
        if (bad_count <= 10) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endfunction

    // Predictor: position and token bookkeeping.
    function automatic void lexer_reset();
        lx_mode  = LX_IDLE;
        exp_seen = 1'b0;
        pt_seen  = 1'b0;
        sp_seen  = 1'b0;
        cur_line = 16'd1;
        cur_col  = 16'd1;
        tok_line = 16'd1;
        tok_col  = 16'd1;
        tok_len  = 0;
    endfunction

    // The error code field reads zero on every beat that is not an error.
    function automatic void emit(input mel_pkg::t_event ev, input mel_pkg::t_kind kind,
                                 input logic [7:0] b, input logic [15:0] ln,
                                 input logic [15:0] col, input int unsigned len,
                                 input bit sp, input mel_pkg::t_err err);
        mel_pkg::t_res r;
        r.event_res    = ev;
        r.token_kind   = kind;
        r.text_byte    = b;
        r.line         = ln;
        r.column       = col;
        r.token_length = 6'(len);
        r.space_before = sp;
        r.error_code   = err;
        r.last         = 1'b0;
        step_buf[step_n] = r;
        step_n++;
    endfunction

    function automatic void raise_err(input mel_pkg::t_err code, input logic [7:0] c);
        lx_mode = LX_ERR;
        emit(mel_pkg::EV_ERR, mel_pkg::K_END, c, cur_line, cur_col, 0, 1'b0, code);
    endfunction

    function automatic void keep_byte(input logic [7:0] c, input mel_pkg::t_kind kind);
        if (tok_len + 1 >= mel_pkg::TOKEN_CAP) begin
            raise_err(mel_pkg::E_TOO_LONG, c);
        end else begin
            tok_len++;
            emit(mel_pkg::EV_TEXT, kind, c, tok_line, tok_col, tok_len, sp_seen,
                 mel_pkg::E_UNEXP);
        end
    endfunction

    function automatic void close_token(input mel_pkg::t_kind kind);
        emit(mel_pkg::EV_DONE, kind, 8'h00, tok_line, tok_col, tok_len, sp_seen,
             mel_pkg::E_UNEXP);
        sp_seen = 1'b0;
        lx_mode = LX_IDLE;
    endfunction

    function automatic void open_token(input t_lex mode);
        tok_line = cur_line;
        tok_col  = cur_col;
        tok_len  = 0;
        exp_seen = 1'b0;
        pt_seen  = 1'b0;
        lx_mode  = mode;
    endfunction

    // A character seen between tokens.
    function automatic void idle_char(input logic [7:0] c);
        mel_pkg::t_kind k;
        k = op_kind(c);
        lx_mode = LX_IDLE;
        if (c == mel_pkg::CH_NUL) begin
            emit(mel_pkg::EV_DONE, mel_pkg::K_END, 8'h00, cur_line, cur_col, 0, sp_seen,
                 mel_pkg::E_UNEXP);
        end else if (blank_ch(c)) begin
            sp_seen = 1'b1;
        end else if (k != mel_pkg::K_END) begin
            open_token(LX_IDLE);
            close_token(k);
        end else if (digit_ch(c)) begin
            open_token(LX_NUM);
            keep_byte(c, mel_pkg::K_NUM);
        end else if (letter_ch(c)) begin
            open_token(LX_ID);
            keep_byte(c, mel_pkg::K_ID);
        end else begin
            raise_err(mel_pkg::E_UNEXP, c);
        end
    endfunction

    // Works out the beats one accepted character causes and queues them.
    function automatic void predict_char(input logic [7:0] c);
        step_n = 0;
        case (lx_mode)
            LX_ERR: begin
            end
            LX_ID: begin
                if (letter_ch(c) || digit_ch(c)) begin
                    keep_byte(c, mel_pkg::K_ID);
                end else begin
                    close_token(mel_pkg::K_ID);
                    idle_char(c);
                end
            end
            LX_NUM: begin
                // Underscores inside a number are dropped without a beat.
                if (c == mel_pkg::CH_E) begin
                    if (exp_seen) begin
                        raise_err(mel_pkg::E_EXP_TWICE, c);
                    end else begin
                        exp_seen = 1'b1;
                        lx_mode  = LX_EXP;
                        keep_byte(c, mel_pkg::K_NUM);
                    end
                end else if (c == mel_pkg::CH_PT) begin
                    if (exp_seen) begin
                        raise_err(mel_pkg::E_PT_IN_EXP, c);
                    end else if (pt_seen) begin
                        raise_err(mel_pkg::E_PT_TWICE, c);
                    end else begin
                        pt_seen = 1'b1;
                        lx_mode = LX_POINT;
                        keep_byte(c, mel_pkg::K_NUM);
                    end
                end else if (digit_ch(c)) begin
                    keep_byte(c, mel_pkg::K_NUM);
                end else if (c != mel_pkg::CH_US) begin
                    close_token(mel_pkg::K_NUM);
                    idle_char(c);
                end
            end
            LX_EXP: begin
                if (c == mel_pkg::CH_PLUS || c == mel_pkg::CH_MINUS) begin
                    lx_mode = LX_SIGN;
                    keep_byte(c, mel_pkg::K_NUM);
                end else if (digit_ch(c)) begin
                    lx_mode = LX_NUM;
                    keep_byte(c, mel_pkg::K_NUM);
                end else begin
                    raise_err(mel_pkg::E_NO_DIGIT, c);
                end
            end
            LX_SIGN, LX_POINT: begin
                if (digit_ch(c)) begin
                    lx_mode = LX_NUM;
                    keep_byte(c, mel_pkg::K_NUM);
                end else begin
                    raise_err(mel_pkg::E_NO_DIGIT, c);
                end
            end
            default: begin
                idle_char(c);
            end
        endcase

        // Position update; a zero byte restarts everything.
        if (c == mel_pkg::CH_NUL) begin
            lx_mode  = LX_IDLE;
            exp_seen = 1'b0;
            pt_seen  = 1'b0;
            cur_line = 16'd1;
            cur_col  = 16'd1;
            tok_len  = 0;
            sp_seen  = 1'b0;
        end else if (c == mel_pkg::CH_NL) begin
            if (cur_line != mel_pkg::SAT16) cur_line++;
            cur_col = 16'd1;
        end else if (cur_col != mel_pkg::SAT16) begin
            cur_col++;
        end

        for (int i = 0; i < step_n; i++) begin
            if (i == step_n - 1) step_buf[i].last = 1'b1;
            want_q.push_back(step_buf[i]);
        end
    endfunction

    // Sends one character beat, idling at random unless calm, and predicts it.
    task automatic send_char(input logic [7:0] c);
        while (!calm && $urandom_range(0, 99) < 29) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_char <= c;
        do @(posedge i_clk); while (!in_if.ready);
        if (lx_mode != LX_ERR && !blank_ch(c)) live_items++;
        predict_char(c);
        sent_items++;
    endtask

    // Holds the input until every owed beat has come out.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Random text builders.
    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0) return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    // Numbers are mostly short; a few run past the token length cap.
    function automatic void put_number();
        bit long_tok;
        int len;
        long_tok = ($urandom_range(0, 39) == 0);
        len = long_tok ? $urandom_range(58, 70) : $urandom_range(1, 4);
        stim_q.push_back(rand_digit());
        for (int j = 1; j < len; j++) begin
            if ($urandom_range(0, 9) == 0) stim_q.push_back(mel_pkg::CH_US);
            stim_q.push_back(rand_digit());
        end
        if (!long_tok && $urandom_range(0, 2) == 0) begin
            stim_q.push_back(mel_pkg::CH_PT);
            repeat ($urandom_range(1, 3)) stim_q.push_back(rand_digit());
        end
        if (!long_tok && $urandom_range(0, 2) == 0) begin
            stim_q.push_back(mel_pkg::CH_E);
            case ($urandom_range(0, 2))
                0:       stim_q.push_back(mel_pkg::CH_PLUS);
                1:       stim_q.push_back(mel_pkg::CH_MINUS);
                default: begin
                end
            endcase
            repeat ($urandom_range(1, 2)) stim_q.push_back(rand_digit());
        end
    endfunction

    function automatic void put_ident();
        int len;
        len = ($urandom_range(0, 39) == 0) ? $urandom_range(58, 70) : $urandom_range(1, 6);
        stim_q.push_back(rand_letter());
        for (int j = 1; j < len; j++) begin
            stim_q.push_back($urandom_range(0, 3) == 0 ? rand_digit() : rand_letter());
        end
    endfunction

    // Malformed numbers: a doubled exponent, a point in the exponent, a doubled point or a missing digit.
    function automatic void put_broken();
        stim_q.push_back(rand_digit());
        case ($urandom_range(0, 4))
            0: begin
                stim_q.push_back(mel_pkg::CH_PT);
                stim_q.push_back(rand_letter());
            end
            1: begin
                stim_q.push_back(mel_pkg::CH_E);
                stim_q.push_back($urandom_range(0, 1) ? mel_pkg::CH_PLUS : mel_pkg::CH_E);
                stim_q.push_back(BLANKS[$urandom_range(0, 5)]);
            end
            2: begin
                stim_q.push_back(mel_pkg::CH_PT);
                stim_q.push_back(rand_digit());
                stim_q.push_back(mel_pkg::CH_PT);
            end
            3: begin
                stim_q.push_back(mel_pkg::CH_E);
                stim_q.push_back(rand_digit());
                stim_q.push_back(mel_pkg::CH_E);
            end
            default: begin
                stim_q.push_back(mel_pkg::CH_E);
                stim_q.push_back(rand_digit());
                stim_q.push_back(mel_pkg::CH_PT);
            end
        endcase
    endfunction

    // One expression: operands and operators with random spacing, usually closed by a zero.
    function automatic void build_expression();
        int n;
        int r;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                stim_q.push_back(8'($urandom_range(0, 255)));
            end else if (r < 9) begin
                put_broken();
            end else if (r < 55) begin
                put_number();
            end else begin
                put_ident();
            end
            if ($urandom_range(0, 9) < 4) stim_q.push_back(BLANKS[$urandom_range(0, 5)]);
            if (i < n - 1) begin
                stim_q.push_back(OPS[$urandom_range(0, 11)]);
                if ($urandom_range(0, 9) < 3) stim_q.push_back(BLANKS[$urandom_range(0, 5)]);
            end
        end
        if ($urandom_range(0, 9) != 0) stim_q.push_back(mel_pkg::CH_NUL);
    endfunction

    // Result side: random back-pressure and the comparison of each beat.
    initial begin
        mel_pkg::t_res got;
        mel_pkg::t_res want;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                got.event_res    = out_if.event_res;
                got.token_kind   = out_if.token_kind;
                got.text_byte    = out_if.text_byte;
                got.line         = out_if.line;
                got.column       = out_if.column;
                got.token_length = out_if.token_length;
                got.space_before = out_if.space_before;
                got.error_code   = out_if.error_code;
                got.last         = out_if.last;
                if (want_q.size() == 0) begin
                    flag_bad({"beat with nothing owed: ", show(got)});
                end else begin
                    want = want_q.pop_front();
                    if (got !== want) begin
                        flag_bad({"want ", show(want), " / got ", show(got)});
                    end
                end
                beats_seen++;
                if (got.event_res == mel_pkg::EV_DONE) tokens_seen++;
                if (got.event_res == mel_pkg::EV_ERR) errors_seen++;
            end
            out_if.ready <= calm || ($urandom_range(0, 99) >= 29);
        end
    end

    // Cycles in which no beat moved on either side.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Watchdog.
    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Watchdog: no beat moved for %0d cycles, %0d beats owed",
                 STALL_LIMIT, want_q.size());
        $display("** math_expression_lexer: FAILED **");
        $finish;
    end

    // Stimulus.
    initial begin
        bit paused;
        mel_pkg::t_res tail;

        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_char = 8'h00;
        lexer_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; typed rows also check the last predicted beat.
        foreach (dir_rows[i]) begin
            send_char(dir_rows[i].ch);
            if (dir_rows[i].typed) begin
                tail = step_buf[step_n > 0 ? step_n - 1 : 0];
                if (step_n == 0 || tail.event_res != dir_rows[i].ev ||
                    tail.token_kind != dir_rows[i].kind ||
                    tail.error_code != dir_rows[i].err) begin
                    flag_bad($sformatf("row %0d (char %02h): table wants ev %0d kind %0d err %0d",
                                       i, dir_rows[i].ch, dir_rows[i].ev, dir_rows[i].kind,
                                       dir_rows[i].err));
                end
            end
        end
        wait_drained();

        // Random expressions, with a calm window and one full drain midway.
        paused = 1'b0;
        while (sent_items < ITEMS) begin
            build_expression();
            while (stim_q.size() != 0) begin
                calm <= sent_items inside {[700:900]};
                send_char(stim_q.pop_front());
            end
            if (!paused && sent_items >= 1200) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (want_q.size() != 0) flag_bad($sformatf("%0d beats never came", want_q.size()));

        $display("Sent %0d characters (%0d live, %0d in the directed table).",
                 sent_items, live_items, $size(dir_rows));
        $display("Checked %0d result beats: %0d tokens, %0d errors; %0d mismatches.",
                 beats_seen, tokens_seen, errors_seen, bad_count);
        if (bad_count == 0) begin
            $display("** math_expression_lexer: PASSED **");
        end else begin
            $display("** math_expression_lexer: FAILED **");
        end
        $finish;
    end

endmodule
